### rtl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_PERIOD       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_LIMIT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LIMIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUSPEND_LIMIT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OVERCURRENT_LIMIT = 3'd6;

	localparam logic [7:0]  RST_HALF_PERIOD       = 8'd50;
	localparam logic [7:0]  RST_FULL_PERIOD       = 8'd100;
	localparam logic [15:0] RST_WAKE_LIMIT        = 16'd10;
	localparam logic [7:0]  RST_BUTTON_LIMIT      = 8'd6;
	localparam logic [7:0]  RST_DISPLAY_LIMIT     = 8'd10;
	localparam logic [15:0] RST_SUSPEND_LIMIT     = 16'd60;
	localparam logic [7:0]  RST_OVERCURRENT_LIMIT = 8'd10;

	typedef struct packed {
		logic button_pressed;
		logic normal_mode;
		logic capacity_display;
		logic accumulate_enable;
		logic wake_enable;
		logic wake_done_in;
		logic long_press_in;
		logic suspend_enable;
		logic suspend_done_in;
		logic overcurrent_enable;
		logic overcurrent_done_in;
	} tts_in_t;

	typedef struct packed {
		logic blink_pulse;
		logic accumulate_pulse;
		logic wake_done;
		logic leave_low_power;
		logic long_press;
		logic display_active;
		logic display_off_pulse;
		logic suspend_done;
		logic overcurrent_done;
	} tts_out_t;

	typedef struct packed {
		logic [7:0]  half_period;
		logic [7:0]  full_period;
		logic [15:0] wake_limit;
		logic [7:0]  button_limit;
		logic [7:0]  display_limit;
		logic [15:0] suspend_limit;
		logic [7:0]  overcurrent_limit;
	} tts_cfg_t;

endpackage

### rtl/tts_in_if.sv
`timescale 1ns / 1ps

interface tts_in_if import tts_pkg::*; ;
	logic    valid;
	logic    ready;
	tts_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/tts_out_if.sv
`timescale 1ns / 1ps

interface tts_out_if import tts_pkg::*; ;
	logic     valid;
	logic     ready;
	tts_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/tts_cfg_if.sv
`timescale 1ns / 1ps

interface tts_cfg_if import tts_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/tts_cfg_regs.sv
`timescale 1ns / 1ps

module tts_cfg_regs import tts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tts_cfg_if.sink   cfg,
	output tts_cfg_t  regs
);

	tts_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.half_period       <= RST_HALF_PERIOD;
			regs_q.full_period       <= RST_FULL_PERIOD;
			regs_q.wake_limit        <= RST_WAKE_LIMIT;
			regs_q.button_limit      <= RST_BUTTON_LIMIT;
			regs_q.display_limit     <= RST_DISPLAY_LIMIT;
			regs_q.suspend_limit     <= RST_SUSPEND_LIMIT;
			regs_q.overcurrent_limit <= RST_OVERCURRENT_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HALF_PERIOD:       regs_q.half_period       <= cfg.data[7:0];
				REG_FULL_PERIOD:       regs_q.full_period       <= cfg.data[7:0];
				REG_WAKE_LIMIT:        regs_q.wake_limit        <= cfg.data;
				REG_BUTTON_LIMIT:      regs_q.button_limit      <= cfg.data[7:0];
				REG_DISPLAY_LIMIT:     regs_q.display_limit     <= cfg.data[7:0];
				REG_SUSPEND_LIMIT:     regs_q.suspend_limit     <= cfg.data;
				REG_OVERCURRENT_LIMIT: regs_q.overcurrent_limit <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/tts_core.sv
`timescale 1ns / 1ps

module tts_core import tts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  tts_in_t  tick,
	input  tts_cfg_t regs,
	output tts_out_t res
);

	logic [7:0]  half_cnt_q, second_cnt_q, button_cnt_q, display_cnt_q, oc_cnt_q;
	logic [15:0] wake_cnt_q, susp_cnt_q;

	logic [7:0]  half_cnt_d, second_cnt_d, button_cnt_d, display_cnt_d, oc_cnt_d;
	logic [15:0] wake_cnt_d, susp_cnt_d;
	logic [7:0]  button_inc, display_inc;
	logic        half_strobe, full_strobe;

	assign half_strobe = half_cnt_q >= regs.half_period;
	assign full_strobe = second_cnt_q >= regs.full_period;

	always_comb begin
		half_cnt_d    = half_strobe ? 8'd1 : half_cnt_q + 8'd1;
		second_cnt_d  = full_strobe ? 8'd1 : second_cnt_q + 8'd1;
		wake_cnt_d    = wake_cnt_q;
		button_cnt_d  = button_cnt_q;
		display_cnt_d = display_cnt_q;
		susp_cnt_d    = susp_cnt_q;
		oc_cnt_d      = oc_cnt_q;
		button_inc    = button_cnt_q;
		display_inc   = display_cnt_q;

		res.blink_pulse       = 1'b0;
		res.accumulate_pulse  = 1'b0;
		res.wake_done         = tick.wake_done_in;
		res.leave_low_power   = 1'b0;
		res.long_press        = tick.long_press_in;
		res.display_active    = tick.capacity_display;
		res.display_off_pulse = 1'b0;
		res.suspend_done      = tick.suspend_done_in;
		res.overcurrent_done  = tick.overcurrent_done_in;

		if (half_strobe) begin
			res.blink_pulse      = 1'b1;
			res.accumulate_pulse = tick.accumulate_enable;

			if (tick.wake_enable && !tick.wake_done_in) begin
				if (wake_cnt_q < regs.wake_limit) begin
					wake_cnt_d = wake_cnt_q + 16'd1;
				end else begin
					wake_cnt_d          = '0;
					res.wake_done       = 1'b1;
					res.leave_low_power = 1'b1;
				end
			end else begin
				wake_cnt_d = '0;
			end

			if (tick.button_pressed) begin
				button_inc = tick.long_press_in ? button_cnt_q : button_cnt_q + 8'd1;
			end else begin
				button_inc = '0;
			end
			button_cnt_d = button_inc;
			if (button_inc >= regs.button_limit) begin
				res.long_press = 1'b1;
				button_cnt_d   = '0;
			end

			display_inc   = tick.capacity_display ? display_cnt_q + 8'd1 : 8'd0;
			display_cnt_d = display_inc;
			if (display_inc >= regs.display_limit) begin
				res.display_active    = 1'b0;
				res.display_off_pulse = 1'b1;
			end
		end

		if (full_strobe && tick.normal_mode) begin
			if (tick.suspend_enable && !tick.suspend_done_in) begin
				if (susp_cnt_q < regs.suspend_limit) begin
					susp_cnt_d = susp_cnt_q + 16'd1;
				end else begin
					susp_cnt_d       = '0;
					res.suspend_done = 1'b1;
				end
			end else begin
				susp_cnt_d = '0;
			end

			if (tick.overcurrent_enable) begin
				if (oc_cnt_q < regs.overcurrent_limit) begin
					oc_cnt_d = oc_cnt_q + 8'd1;
				end else begin
					res.overcurrent_done = 1'b1;
				end
			end else begin
				oc_cnt_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cnt_q    <= '0;
			second_cnt_q  <= '0;
			wake_cnt_q    <= '0;
			button_cnt_q  <= '0;
			display_cnt_q <= '0;
			susp_cnt_q    <= '0;
			oc_cnt_q      <= '0;
		end else if (step) begin
			half_cnt_q    <= half_cnt_d;
			second_cnt_q  <= second_cnt_d;
			wake_cnt_q    <= wake_cnt_d;
			button_cnt_q  <= button_cnt_d;
			display_cnt_q <= display_cnt_d;
			susp_cnt_q    <= susp_cnt_d;
			oc_cnt_q      <= oc_cnt_d;
		end
	end

endmodule

### rtl/tick_timeout_supervisor.sv
`timescale 1ns / 1ps
// Tick timeout supervisor.
// tick:   one word per base tick: button level, normal-mode flag and the
//         software status flags as currently held.
// result: one word per tick: blink/accumulate/leave-low-power/display-off
//         pulses and the updated status flags.
// cfg:    register writes (index, data), always ready; write only while idle.
// Both data channels are valid/ready. A tick word is registered on entry,
// evaluated against the prescaler and timeout counters, and the result is
// registered on exit. One tick per cycle is sustained while result.ready
// stays high; the counters step when a word moves from the input register
// into the result register.
// When result.ready is low the result register holds, the input register
// still takes one more word, and tick.ready then drops until the result is
// taken. Reset clears both valid flags, all counters, and loads the
// default register values.
module tick_timeout_supervisor import tts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tts_in_if.sink    tick,
	tts_out_if.source result,
	tts_cfg_if.sink   cfg
);

	tts_cfg_t regs;
	tts_in_t  item_s1;
	logic     valid_s1;
	tts_out_t res_d;
	tts_out_t result_s2;
	logic     valid_s2;
	logic     advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

	tts_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (item_s1),
		.regs   (regs),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= tick.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_d;
		end
	end

	a_acc_needs_blink: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.accumulate_pulse |-> result_s2.blink_pulse)
		else $error("accumulate pulse without half-second strobe");

	a_leave_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.leave_low_power |-> result_s2.wake_done)
		else $error("leave low power without wake done");

	a_disp_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.display_off_pulse |-> !result_s2.display_active)
		else $error("display off pulse with display still active");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> tick.ready)
		else $error("input stage empty but not ready");

endmodule
